// File: src/spcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spcf_pkg;

    // Command codes carried on the input channel.
    localparam logic [2:0] CMD_LOAD_SRC = 3'd0;
    localparam logic [2:0] CMD_LOAD_TGT = 3'd1;
    localparam logic [2:0] CMD_START    = 3'd2;
    localparam logic [2:0] CMD_ADVANCE  = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    // Order in which the blend unit walks the interpolated fields.
    localparam logic [2:0] FLD_AZIMUTH   = 3'd0;
    localparam logic [2:0] FLD_ELEVATION = 3'd1;
    localparam logic [2:0] FLD_DISTANCE  = 3'd2;
    localparam logic [2:0] FLD_GAIN      = 3'd3;
    localparam logic [2:0] FLD_WIDTH     = 3'd4;
    localparam logic [2:0] FLD_REVERB    = 3'd5;

    localparam int          LEN_W      = 24;
    localparam int          PROG_W     = 17;
    localparam logic [16:0] PROG_FULL  = 17'h10000;
    localparam logic [16:0] PROG_HALF  = 17'h08000;
    localparam int          DIV_STEPS  = 16;

    typedef struct packed {
        logic        active;
        logic [3:0]  algorithm;
        logic [15:0] azimuth;
        logic [15:0] elevation;
        logic [23:0] distance;
        logic [23:0] gain;
        logic [23:0] width;
        logic [23:0] reverb;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic wr_target;
        logic rd_en;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_BLEND,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: src/scene_parameter_crossfade_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Crossfades per-object scene parameters between a source and a target store.
// Input channel (s_valid/s_ready): one command per transaction: load source,
// load target, start, advance or query. Every transaction returns exactly one
// result transaction on the output channel (m_valid/m_ready) carrying the fade
// flag, the progress in Q16 and, for a query, the interpolated object.
// The fade length register is written through cfg_wr_en/cfg_wr_data with no
// wait state; write it only while no transaction is in flight.
// Progress comes from a 16-step restoring divider, and a query then runs six
// fields through one shared 25x18 multiplier. When progress is already full,
// the divider saturates at once and skips its steps. One transaction is
// worked at a time: the next is not accepted until the last has gone to the
// output register.
// A finished result sits in the output register; the next input transaction
// is taken while it waits, but the block holds its following result until the
// receiver takes the previous one.
// Reset clears the fade length, the elapsed count and the fade flag. Object
// stores are not cleared: query only entries that were loaded.
module scene_parameter_crossfade_core #(
    parameter int NUM_OBJECTS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_command,
    input  wire logic [7:0]         s_object_index,
    input  wire logic [15:0]        s_sample_count,
    input  wire logic               s_entry_active,
    input  wire logic [3:0]         s_entry_algorithm,
    input  wire logic signed [15:0] s_entry_azimuth,
    input  wire logic signed [15:0] s_entry_elevation,
    input  wire logic signed [23:0] s_entry_distance,
    input  wire logic signed [23:0] s_entry_gain,
    input  wire logic signed [23:0] s_entry_width,
    input  wire logic signed [23:0] s_entry_reverb,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_fading,
    output logic [16:0]             m_progress,
    output logic                    m_obj_active,
    output logic [3:0]              m_obj_algorithm,
    output logic signed [15:0]      m_azimuth,
    output logic signed [15:0]      m_elevation,
    output logic signed [23:0]      m_distance,
    output logic signed [23:0]      m_gain,
    output logic signed [23:0]      m_width,
    output logic signed [23:0]      m_reverb
);

    localparam int         ADDR_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam logic [8:0] OBJ_CNT = 9'(NUM_OBJECTS);

    spcf_pkg::state_t   state_reg, state_next;
    logic [23:0]        fade_len_reg;
    logic [23:0]        elapsed_reg, elapsed_next;
    logic               running_reg, running_next;
    logic               query_reg;
    logic               m_valid_reg;
    logic               m_fading_reg;
    logic [16:0]        m_progress_reg;
    spcf_pkg::entry_t   m_obj_reg;

    logic               accept;
    logic               idx_ok;
    logic [24:0]        adv_sum;
    logic               div_start;
    logic               div_done;
    logic [16:0]        div_quot;
    logic               blend_start;
    logic               blend_done;
    logic               out_load;
    spcf_pkg::mem_req_t mem_req;
    spcf_pkg::entry_t   wr_entry;
    spcf_pkg::entry_t   src_q;
    spcf_pkg::entry_t   tgt_q;
    spcf_pkg::entry_t   blend_res;

    assign s_ready = (state_reg == spcf_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign idx_ok  = ({1'b0, s_object_index} < OBJ_CNT);

    assign wr_entry.active    = s_entry_active;
    assign wr_entry.algorithm = s_entry_algorithm;
    assign wr_entry.azimuth   = s_entry_azimuth;
    assign wr_entry.elevation = s_entry_elevation;
    assign wr_entry.distance  = s_entry_distance;
    assign wr_entry.gain      = s_entry_gain;
    assign wr_entry.width     = s_entry_width;
    assign wr_entry.reverb    = s_entry_reverb;

    assign mem_req.wr_en     = accept && idx_ok &&
                               ((s_command == spcf_pkg::CMD_LOAD_SRC) ||
                                (s_command == spcf_pkg::CMD_LOAD_TGT));
    assign mem_req.wr_target = (s_command == spcf_pkg::CMD_LOAD_TGT);
    assign mem_req.rd_en     = accept;

    spcf_store #(
        .NUM_OBJECTS(NUM_OBJECTS)
    ) u_store (
        .aclk   (aclk),
        .req    (mem_req),
        .addr   (s_object_index[ADDR_W-1:0]),
        .wr_data(wr_entry),
        .src_q  (src_q),
        .tgt_q  (tgt_q)
    );

    // Fade timer update, applied when the transaction is accepted.
    assign adv_sum = {1'b0, elapsed_reg} + {9'd0, s_sample_count};

    always_comb begin
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        if (accept) begin
            if (s_command == spcf_pkg::CMD_START) begin
                elapsed_next = '0;
                running_next = (fade_len_reg != '0);
            end else if (s_command == spcf_pkg::CMD_ADVANCE && running_reg) begin
                if (adv_sum >= {1'b0, fade_len_reg}) begin
                    elapsed_next = fade_len_reg;
                    running_next = 1'b0;
                end else begin
                    elapsed_next = adv_sum[23:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_len_reg <= '0;
            elapsed_reg  <= '0;
            running_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fade_len_reg <= cfg_wr_data;
            end
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            query_reg <= (s_command == spcf_pkg::CMD_QUERY) && idx_ok;
        end
    end

    spcf_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(elapsed_reg),
        .divisor (fade_len_reg),
        .done    (div_done),
        .quotient(div_quot)
    );

    spcf_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blend_start),
        .progress(div_quot),
        .src     (src_q),
        .tgt     (tgt_q),
        .done    (blend_done),
        .result  (blend_res)
    );

    always_comb begin
        state_next  = state_reg;
        div_start   = 1'b0;
        blend_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            spcf_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = spcf_pkg::ST_START;
                end
            end
            spcf_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = spcf_pkg::ST_DIV;
            end
            spcf_pkg::ST_DIV: begin
                if (div_done) begin
                    if (query_reg) begin
                        blend_start = 1'b1;
                        state_next  = spcf_pkg::ST_BLEND;
                    end else begin
                        state_next = spcf_pkg::ST_OUT;
                    end
                end
            end
            spcf_pkg::ST_BLEND: begin
                if (blend_done) begin
                    state_next = spcf_pkg::ST_OUT;
                end
            end
            spcf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = spcf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spcf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_fading_reg   <= running_reg;
            m_progress_reg <= div_quot;
            m_obj_reg      <= query_reg ? blend_res : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_fading        = m_fading_reg;
    assign m_progress      = m_progress_reg;
    assign m_obj_active    = m_obj_reg.active;
    assign m_obj_algorithm = m_obj_reg.algorithm;
    assign m_azimuth       = m_obj_reg.azimuth;
    assign m_elevation     = m_obj_reg.elevation;
    assign m_distance      = m_obj_reg.distance;
    assign m_gain          = m_obj_reg.gain;
    assign m_width         = m_obj_reg.width;
    assign m_reverb        = m_obj_reg.reverb;

    a_progress_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_progress_reg <= spcf_pkg::PROG_FULL)
        else $error("result progress above full scale");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == spcf_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_blend_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_done |-> state_reg == spcf_pkg::ST_BLEND)
        else $error("blend finished outside the blend state");

endmodule

`default_nettype wire

// File: src/spcf_store.sv
`timescale 1ns / 1ps
`default_nettype none

module spcf_store #(
    parameter int NUM_OBJECTS = 64,
    localparam int ADDR_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1
) (
    input  wire logic               aclk,
    input  wire spcf_pkg::mem_req_t req,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire spcf_pkg::entry_t   wr_data,
    output spcf_pkg::entry_t        src_q,
    output spcf_pkg::entry_t        tgt_q
);

    spcf_pkg::entry_t src_mem [NUM_OBJECTS];
    spcf_pkg::entry_t tgt_mem [NUM_OBJECTS];
    spcf_pkg::entry_t src_q_reg;
    spcf_pkg::entry_t tgt_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en && !req.wr_target) begin
            src_mem[addr] <= wr_data;
        end
        if (req.rd_en) begin
            src_q_reg <= src_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en && req.wr_target) begin
            tgt_mem[addr] <= wr_data;
        end
        if (req.rd_en) begin
            tgt_q_reg <= tgt_mem[addr];
        end
    end

    assign src_q = src_q_reg;
    assign tgt_q = tgt_q_reg;

endmodule

`default_nettype wire

// File: src/spcf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module spcf_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [23:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             done,
    output logic [16:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] div_reg, div_next;
    logic [16:0] quot_reg, quot_next;
    logic [24:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = (shifted >= {1'b0, div_reg});

    // Restoring division of dividend * 65536 by divisor, one quotient bit per cycle.
    // A dividend at or above the divisor saturates to full progress at once.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (start) begin
            div_next = divisor;
            cnt_next = '0;
            if (dividend >= divisor) begin
                quot_next = spcf_pkg::PROG_FULL;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next  = dividend;
                quot_next = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = 24'(shifted - {1'b0, div_reg});
            end else begin
                rem_next = shifted[23:0];
            end
            quot_next = {quot_reg[15:0], fits};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'(spcf_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < div_reg)
        else $error("divider remainder reached the divisor");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> quot_reg <= spcf_pkg::PROG_FULL)
        else $error("divider quotient above full progress");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg || $past(start))
        else $error("divider done held without a new start");

endmodule

`default_nettype wire

// File: src/spcf_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module spcf_blend (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [16:0]      progress,
    input  wire spcf_pkg::entry_t src,
    input  wire spcf_pkg::entry_t tgt,
    output logic                  done,
    output spcf_pkg::entry_t      result
);

    logic             busy_reg;
    logic [2:0]       cnt_reg;
    logic             wb_valid_reg;
    logic [2:0]       wb_idx_reg;
    logic             done_reg;
    logic signed [42:0] prod_reg;
    logic [23:0]      base_reg;
    spcf_pkg::entry_t res_reg;

    logic [23:0]        a_sel;
    logic [23:0]        b_sel;
    logic               is_angle;
    logic [15:0]        ang_diff;
    logic [24:0]        lin_diff;
    logic signed [24:0] d_w;
    logic signed [17:0] t_s;
    logic signed [42:0] mul_w;
    logic signed [42:0] rnd_w;
    logic signed [42:0] shr_w;
    logic [23:0]        sum_w;

    always_comb begin
        a_sel    = '0;
        b_sel    = '0;
        is_angle = 1'b0;
        unique case (cnt_reg)
            spcf_pkg::FLD_AZIMUTH: begin
                a_sel    = {8'd0, src.azimuth};
                b_sel    = {8'd0, tgt.azimuth};
                is_angle = 1'b1;
            end
            spcf_pkg::FLD_ELEVATION: begin
                a_sel    = {8'd0, src.elevation};
                b_sel    = {8'd0, tgt.elevation};
                is_angle = 1'b1;
            end
            spcf_pkg::FLD_DISTANCE: begin
                a_sel = src.distance;
                b_sel = tgt.distance;
            end
            spcf_pkg::FLD_GAIN: begin
                a_sel = src.gain;
                b_sel = tgt.gain;
            end
            spcf_pkg::FLD_WIDTH: begin
                a_sel = src.width;
                b_sel = tgt.width;
            end
            spcf_pkg::FLD_REVERB: begin
                a_sel = src.reverb;
                b_sel = tgt.reverb;
            end
            default: begin
                a_sel    = '0;
                b_sel    = '0;
                is_angle = 1'b0;
            end
        endcase
    end

    // Angles take the wrapped 16-bit difference, so the shorter arc is followed.
    assign ang_diff = b_sel[15:0] - a_sel[15:0];
    assign lin_diff = {b_sel[23], b_sel} - {a_sel[23], a_sel};
    assign d_w      = is_angle ? $signed({{9{ang_diff[15]}}, ang_diff}) : $signed(lin_diff);
    assign t_s      = $signed({1'b0, progress});
    assign mul_w    = d_w * t_s;

    assign rnd_w = prod_reg + 43'sd32768;
    assign shr_w = rnd_w >>> 16;
    assign sum_w = base_reg + shr_w[23:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg     <= wb_valid_reg && (wb_idx_reg == spcf_pkg::FLD_REVERB);
            wb_valid_reg <= busy_reg;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= spcf_pkg::FLD_AZIMUTH;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == spcf_pkg::FLD_REVERB) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= mul_w;
        base_reg   <= a_sel;
        wb_idx_reg <= cnt_reg;
        if (start) begin
            // Discrete fields switch over at half progress.
            if (progress < spcf_pkg::PROG_HALF) begin
                res_reg.active    <= src.active;
                res_reg.algorithm <= src.algorithm;
            end else begin
                res_reg.active    <= tgt.active;
                res_reg.algorithm <= tgt.algorithm;
            end
        end
        if (wb_valid_reg) begin
            unique case (wb_idx_reg)
                spcf_pkg::FLD_AZIMUTH:   res_reg.azimuth   <= sum_w[15:0];
                spcf_pkg::FLD_ELEVATION: res_reg.elevation <= sum_w[15:0];
                spcf_pkg::FLD_DISTANCE:  res_reg.distance  <= sum_w;
                spcf_pkg::FLD_GAIN:      res_reg.gain      <= sum_w;
                spcf_pkg::FLD_WIDTH:     res_reg.width     <= sum_w;
                spcf_pkg::FLD_REVERB:    res_reg.reverb    <= sum_w;
                default:                 res_reg.reverb    <= res_reg.reverb;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// File: sim/tb_scene_parameter_crossfade_core.sv
`timescale 1ns / 1ps

module tb_scene_parameter_crossfade_core;

    localparam int NUM_OBJ       = 64;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    // Command codes the block does not define; it must answer them without
    // touching its state.
    localparam logic [2:0]  CMD_RSVD_5 = 3'd5;
    localparam logic [2:0]  CMD_RSVD_6 = 3'd6;
    localparam logic [2:0]  CMD_RSVD_7 = 3'd7;
    localparam logic [23:0] LEN_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]       command;
        logic [7:0]       object_index;
        logic [15:0]      sample_count;
        spcf_pkg::entry_t entry;
    } fade_command_t;

    typedef struct packed {
        logic             fading;
        logic [16:0]      progress;
        spcf_pkg::entry_t obj;
    } fade_result_t;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_CYCLIC
    } rx_mode_t;

    class crossfade_scoreboard;
        logic [23:0]      fade_len;
        logic [23:0]      elapsed;
        logic             running;
        spcf_pkg::entry_t src_store [NUM_OBJ];
        spcf_pkg::entry_t tgt_store [NUM_OBJ];
        fade_result_t     expected_blends [$];
        int unsigned      errors;

        function new();
            fade_len = '0;
            elapsed  = '0;
            running  = 1'b0;
            errors   = 0;
        endfunction

        function void set_length(logic [23:0] value);
            fade_len = value;
        endfunction

        function logic [16:0] progress_q16();
            longint q;
            if (fade_len == 0) return spcf_pkg::PROG_FULL;
            q = (longint'(elapsed) << 16) / longint'(fade_len);
            return (q > longint'(spcf_pkg::PROG_FULL)) ? spcf_pkg::PROG_FULL : q[16:0];
        endfunction

        // The difference is wrapped to 16 bits first, so the blend takes the
        // shorter way around the circle.
        function logic [15:0] blend_angle(logic [15:0] a, logic [15:0] b, logic [16:0] t);
            logic [15:0] diff;
            longint      d;
            longint      r;
            diff = b - a;
            d    = longint'($signed(diff));
            r    = longint'($signed(a)) + ((d * longint'(t) + 64'sd32768) >>> 16);
            return r[15:0];
        endfunction

        function logic [23:0] blend_linear(logic [23:0] a, logic [23:0] b, logic [16:0] t);
            longint d;
            longint r;
            d = longint'($signed(b)) - longint'($signed(a));
            r = longint'($signed(a)) + ((d * longint'(t) + 64'sd32768) >>> 16);
            return r[23:0];
        endfunction

        function void note_command(fade_command_t c);
            fade_result_t     res;
            logic [16:0]      t;
            logic [31:0]      sum;
            spcf_pkg::entry_t s;
            spcf_pkg::entry_t g;
            case (c.command)
                spcf_pkg::CMD_LOAD_SRC: begin
                    if (c.object_index < NUM_OBJ) src_store[c.object_index] = c.entry;
                end
                spcf_pkg::CMD_LOAD_TGT: begin
                    if (c.object_index < NUM_OBJ) tgt_store[c.object_index] = c.entry;
                end
                spcf_pkg::CMD_START: begin
                    elapsed = '0;
                    running = (fade_len != 0);
                end
                spcf_pkg::CMD_ADVANCE: begin
                    if (running) begin
                        sum = elapsed + c.sample_count;
                        if (sum >= fade_len) begin
                            sum     = fade_len;
                            running = 1'b0;
                        end
                        elapsed = sum[23:0];
                    end
                end
                default: ;
            endcase
            t            = progress_q16();
            res.fading   = running;
            res.progress = t;
            res.obj      = '0;
            if (c.command == spcf_pkg::CMD_QUERY && c.object_index < NUM_OBJ) begin
                s = src_store[c.object_index];
                g = tgt_store[c.object_index];
                res.obj.active    = (t < spcf_pkg::PROG_HALF) ? s.active : g.active;
                res.obj.algorithm = (t < spcf_pkg::PROG_HALF) ? s.algorithm : g.algorithm;
                res.obj.azimuth   = blend_angle(s.azimuth, g.azimuth, t);
                res.obj.elevation = blend_angle(s.elevation, g.elevation, t);
                res.obj.distance  = blend_linear(s.distance, g.distance, t);
                res.obj.gain      = blend_linear(s.gain, g.gain, t);
                res.obj.width     = blend_linear(s.width, g.width, t);
                res.obj.reverb    = blend_linear(s.reverb, g.reverb, t);
            end
            expected_blends.push_back(res);
        endfunction

        task report(string what, longint got, longint want);
            if (errors < 60)
                $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(fade_result_t got);
            fade_result_t want;
            if (expected_blends.size() == 0) begin
                report("result with no transaction outstanding, progress", got.progress, 0);
                return;
            end
            want = expected_blends.pop_front();
            if (got.fading !== want.fading) report("fading", got.fading, want.fading);
            if (got.progress !== want.progress) report("progress", got.progress, want.progress);
            if (got.obj.active !== want.obj.active)
                report("obj_active", got.obj.active, want.obj.active);
            if (got.obj.algorithm !== want.obj.algorithm)
                report("obj_algorithm", got.obj.algorithm, want.obj.algorithm);
            if (got.obj.azimuth !== want.obj.azimuth)
                report("azimuth", got.obj.azimuth, want.obj.azimuth);
            if (got.obj.elevation !== want.obj.elevation)
                report("elevation", got.obj.elevation, want.obj.elevation);
            if (got.obj.distance !== want.obj.distance)
                report("distance", got.obj.distance, want.obj.distance);
            if (got.obj.gain !== want.obj.gain) report("gain", got.obj.gain, want.obj.gain);
            if (got.obj.width !== want.obj.width) report("width", got.obj.width, want.obj.width);
            if (got.obj.reverb !== want.obj.reverb)
                report("reverb", got.obj.reverb, want.obj.reverb);
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [23:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_command;
    logic [7:0]         s_object_index;
    logic [15:0]        s_sample_count;
    logic               s_entry_active;
    logic [3:0]         s_entry_algorithm;
    logic signed [15:0] s_entry_azimuth;
    logic signed [15:0] s_entry_elevation;
    logic signed [23:0] s_entry_distance;
    logic signed [23:0] s_entry_gain;
    logic signed [23:0] s_entry_width;
    logic signed [23:0] s_entry_reverb;
    logic               m_valid;
    logic               m_ready;
    logic               m_fading;
    logic [16:0]        m_progress;
    logic               m_obj_active;
    logic [3:0]         m_obj_algorithm;
    logic signed [15:0] m_azimuth;
    logic signed [15:0] m_elevation;
    logic signed [23:0] m_distance;
    logic signed [23:0] m_gain;
    logic signed [23:0] m_width;
    logic signed [23:0] m_reverb;

    crossfade_scoreboard sb;
    bit                  hold_request = 1'b0;
    bit                  hold_done    = 1'b0;
    bit                  src_loaded [NUM_OBJ];
    bit                  tgt_loaded [NUM_OBJ];
    bit                  listed [NUM_OBJ];
    logic [7:0]          queryable [$];

    scene_parameter_crossfade_core #(
        .NUM_OBJECTS(NUM_OBJ)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_object_index    (s_object_index),
        .s_sample_count    (s_sample_count),
        .s_entry_active    (s_entry_active),
        .s_entry_algorithm (s_entry_algorithm),
        .s_entry_azimuth   (s_entry_azimuth),
        .s_entry_elevation (s_entry_elevation),
        .s_entry_distance  (s_entry_distance),
        .s_entry_gain      (s_entry_gain),
        .s_entry_width     (s_entry_width),
        .s_entry_reverb    (s_entry_reverb),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fading          (m_fading),
        .m_progress        (m_progress),
        .m_obj_active      (m_obj_active),
        .m_obj_algorithm   (m_obj_algorithm),
        .m_azimuth         (m_azimuth),
        .m_elevation       (m_elevation),
        .m_distance        (m_distance),
        .m_gain            (m_gain),
        .m_width           (m_width),
        .m_reverb          (m_reverb)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic spcf_pkg::entry_t noise_entry();
        logic [191:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(spcf_pkg::entry_t)-1:0];
    endfunction

    // Valid is raised here and only lowered by the callers that idle or
    // drain, so back-to-back transactions never see a low and a high in one step.
    task automatic send_command(input fade_command_t c);
        s_valid           <= 1'b1;
        s_command         <= c.command;
        s_object_index    <= c.object_index;
        s_sample_count    <= c.sample_count;
        s_entry_active    <= c.entry.active;
        s_entry_algorithm <= c.entry.algorithm;
        s_entry_azimuth   <= c.entry.azimuth;
        s_entry_elevation <= c.entry.elevation;
        s_entry_distance  <= c.entry.distance;
        s_entry_gain      <= c.entry.gain;
        s_entry_width     <= c.entry.width;
        s_entry_reverb    <= c.entry.reverb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [7:0] idx, input logic [15:0] ns);
        fade_command_t c;
        c.command      = cmd;
        c.object_index = idx;
        c.sample_count = ns;
        c.entry        = noise_entry();
        send_command(c);
    endtask

    // In-range queries only go to entries that hold both a source and a target.
    task automatic load_entry(input logic [2:0] cmd, input logic [7:0] idx,
                              input spcf_pkg::entry_t e);
        fade_command_t c;
        c.command      = cmd;
        c.object_index = idx;
        c.sample_count = 16'($urandom);
        c.entry        = e;
        if (idx < NUM_OBJ) begin
            if (cmd == spcf_pkg::CMD_LOAD_SRC) src_loaded[idx] = 1'b1;
            else tgt_loaded[idx] = 1'b1;
            if (src_loaded[idx] && tgt_loaded[idx] && !listed[idx]) begin
                listed[idx] = 1'b1;
                queryable.push_back(idx);
            end
        end
        send_command(c);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_blends.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(input logic [23:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    always @(posedge aclk) begin : sample_handshakes
        fade_result_t  got;
        fade_command_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.fading   = m_fading;
                got.progress = m_progress;
                got.obj      = spcf_pkg::entry_t'{active: m_obj_active,
                                                  algorithm: m_obj_algorithm,
                                                  azimuth: m_azimuth, elevation: m_elevation,
                                                  distance: m_distance, gain: m_gain,
                                                  width: m_width, reverb: m_reverb};
                sb.check_result(got);
            end
            if (s_valid && s_ready) begin
                seen.command      = s_command;
                seen.object_index = s_object_index;
                seen.sample_count = s_sample_count;
                seen.entry        = spcf_pkg::entry_t'{active: s_entry_active,
                                                       algorithm: s_entry_algorithm,
                                                       azimuth: s_entry_azimuth,
                                                       elevation: s_entry_elevation,
                                                       distance: s_entry_distance,
                                                       gain: s_entry_gain,
                                                       width: s_entry_width,
                                                       reverb: s_entry_reverb};
                sb.note_command(seen);
            end
            if (cfg_wr_en) sb.set_length(cfg_wr_data);
        end
    end

    initial begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned held;
        int unsigned beat;
        m_ready   <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        beat      = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                // Long hold-off: the block fills up and must stall its input.
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                beat++;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ((beat % 5) < 2);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_scene_parameter_crossfade_core: done, errors");
        $finish;
    end

    initial begin
        int unsigned total;
        int unsigned phase;
        int unsigned n;
        int unsigned gap;
        int unsigned burst_left;
        int unsigned pick;
        int unsigned span;
        logic [23:0] len;
        logic [7:0]  idx;
        logic [15:0] ns;
        logic [2:0]  cmd;

        sb = new();
        aresetn           <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        s_valid           <= 1'b0;
        s_command         <= '0;
        s_object_index    <= '0;
        s_sample_count    <= '0;
        s_entry_active    <= 1'b0;
        s_entry_algorithm <= '0;
        s_entry_azimuth   <= '0;
        s_entry_elevation <= '0;
        s_entry_distance  <= '0;
        s_entry_gain      <= '0;
        s_entry_width     <= '0;
        s_entry_reverb    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero length: every in-range query sits at the target.
        write_length(24'd0);
        load_entry(spcf_pkg::CMD_LOAD_SRC, 8'd0, spcf_pkg::entry_t'{active: 1'b1,
                   algorithm: 4'hF, azimuth: 16'h7FFF, elevation: 16'h8000,
                   distance: 24'h7FFFFF, gain: 24'h800000, width: 24'h000000,
                   reverb: 24'hFFFFFF});
        load_entry(spcf_pkg::CMD_LOAD_TGT, 8'd0, spcf_pkg::entry_t'{active: 1'b0,
                   algorithm: 4'h0, azimuth: 16'h8000, elevation: 16'h7FFF,
                   distance: 24'h800000, gain: 24'h7FFFFF, width: 24'h7FFFFF,
                   reverb: 24'h000000});
        // Entry 1 has exact half-turns on both angles.
        load_entry(spcf_pkg::CMD_LOAD_SRC, 8'd1, spcf_pkg::entry_t'{active: 1'b0,
                   algorithm: 4'h5, azimuth: 16'h0000, elevation: 16'h4000,
                   distance: 24'h000000, gain: 24'h000000, width: 24'h001000,
                   reverb: 24'h123456});
        load_entry(spcf_pkg::CMD_LOAD_TGT, 8'd1, spcf_pkg::entry_t'{active: 1'b1,
                   algorithm: 4'hA, azimuth: 16'h8000, elevation: 16'hC000,
                   distance: 24'h001000, gain: 24'hFFF000, width: 24'h7FFFFF,
                   reverb: 24'h800000});
        load_entry(spcf_pkg::CMD_LOAD_SRC, 8'(NUM_OBJ - 1), noise_entry());
        load_entry(spcf_pkg::CMD_LOAD_TGT, 8'(NUM_OBJ - 1), noise_entry());
        load_entry(spcf_pkg::CMD_LOAD_SRC, 8'(NUM_OBJ), noise_entry());
        load_entry(spcf_pkg::CMD_LOAD_TGT, 8'hFF, noise_entry());
        issue(spcf_pkg::CMD_QUERY, 8'd0, 16'd0);
        issue(spcf_pkg::CMD_QUERY, 8'd1, 16'd0);
        issue(spcf_pkg::CMD_QUERY, 8'(NUM_OBJ), 16'd0);
        issue(spcf_pkg::CMD_QUERY, 8'hFF, 16'hFFFF);
        issue(spcf_pkg::CMD_ADVANCE, 8'd0, 16'hFFFF);
        issue(spcf_pkg::CMD_START, 8'd0, 16'd0);
        issue(CMD_RSVD_5, 8'd0, 16'd0);
        issue(CMD_RSVD_6, 8'd1, 16'd1);
        issue(CMD_RSVD_7, 8'hFF, 16'hFFFF);

        // Length two: one sample lands exactly on the half-way switch.
        drain();
        write_length(24'd2);
        issue(spcf_pkg::CMD_START, 8'd0, 16'd0);
        issue(spcf_pkg::CMD_QUERY, 8'd0, 16'd0);
        issue(spcf_pkg::CMD_ADVANCE, 8'd0, 16'd1);
        issue(spcf_pkg::CMD_QUERY, 8'd1, 16'd0);
        issue(spcf_pkg::CMD_ADVANCE, 8'd0, 16'hFFFF);
        issue(spcf_pkg::CMD_QUERY, 8'd0, 16'd0);

        // Longest fade, then shortened while it runs.
        drain();
        write_length(LEN_MAX);
        issue(spcf_pkg::CMD_START, 8'd0, 16'd0);
        issue(spcf_pkg::CMD_ADVANCE, 8'd0, 16'hFFFF);
        issue(spcf_pkg::CMD_QUERY, 8'd1, 16'd0);
        drain();
        write_length(24'd100);
        issue(spcf_pkg::CMD_QUERY, 8'd1, 16'd0);
        issue(spcf_pkg::CMD_ADVANCE, 8'd0, 16'd0);
        issue(spcf_pkg::CMD_QUERY, 8'(NUM_OBJ - 1), 16'd0);

        total      = 0;
        phase      = 0;
        burst_left = 0;
        len        = 24'd100;
        while (total < RANDOM_ITEMS) begin
            drain();
            case ($urandom_range(0, 9))
                0:       len = 24'd0;
                1:       len = 24'd1;
                2:       len = LEN_MAX;
                3, 4, 5: len = 24'($urandom_range(2, 300));
                6, 7, 8: len = 24'($urandom_range(301, 70000));
                default: len = 24'($urandom_range(70001, 32'hFFFFFE));
            endcase
            write_length(len);
            n = $urandom_range(20, 60);
            if (phase == 2) begin
                hold_request = 1'b1;
                n = 60;
            end
            repeat (n) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 4);
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
                burst_left--;
                pick = $urandom_range(0, 99);
                if (pick < 24) begin
                    cmd = (pick < 12) ? spcf_pkg::CMD_LOAD_SRC : spcf_pkg::CMD_LOAD_TGT;
                    idx = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, NUM_OBJ - 1));
                    load_entry(cmd, idx, noise_entry());
                end else if (pick < 30) begin
                    issue(spcf_pkg::CMD_START, 8'($urandom), 16'($urandom));
                end else if (pick < 60) begin
                    // Steps sized to the fade so progress walks through its range.
                    span = len / 6;
                    if (span > 65535) span = 65535;
                    if (span == 0) span = 1;
                    case ($urandom_range(0, 3))
                        0, 1:    ns = 16'($urandom_range(0, span));
                        2:       ns = 16'($urandom);
                        default: ns = 16'($urandom_range(0, 7));
                    endcase
                    issue(spcf_pkg::CMD_ADVANCE, 8'($urandom), ns);
                end else if (pick < 96) begin
                    if (queryable.size() != 0 && $urandom_range(0, 9) != 0)
                        idx = queryable[$urandom_range(0, queryable.size() - 1)];
                    else
                        idx = 8'($urandom_range(NUM_OBJ, 255));
                    issue(spcf_pkg::CMD_QUERY, idx, 16'($urandom));
                end else begin
                    issue(CMD_RSVD_5 + 3'($urandom_range(0, 2)), 8'($urandom), 16'($urandom));
                end
                total++;
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb_scene_parameter_crossfade_core: done, clean");
        else
            $display("tb_scene_parameter_crossfade_core: done, errors");
        $finish;
    end

endmodule

// File: scene_parameter_crossfade_core.f
src/spcf_pkg.sv
src/spcf_store.sv
src/spcf_divider.sv
src/spcf_blend.sv
src/scene_parameter_crossfade_core.sv
sim/tb_scene_parameter_crossfade_core.sv
